// ----- src/okl_pkg.sv -----
// ----------------------------------------------------------------------------
// okl_pkg: shared constants and coefficient tables
// Fixed-point coefficients for the OKLab -> LMS' and LMS^3 -> RGB matrices.
// ----------------------------------------------------------------------------
package okl_pkg;

    localparam int COEF_BITS  = 24;
    localparam int GUARD_BITS = 8;
    localparam int COEF_W     = 28;
    localparam int LUM_W      = 15;
    localparam int AB_W       = 14;
    localparam int CH_W       = 15;

    typedef logic signed [COEF_W-1:0] coef_t;

    // decimal constant with ten fraction digits -> Q.COEF_BITS, nearest, ties up
    function automatic coef_t kpos(input longint d);
        longint t;
        t = (d * (64'sd1 <<< COEF_BITS) + 64'sd5000000000) / 64'sd10000000000;
        return t[COEF_W-1:0];
    endfunction

    function automatic coef_t kneg(input longint d);
        coef_t k;
        k = kpos(d);
        return coef_t'(-k);
    endfunction

    localparam coef_t MAT_IN [3][2] = '{
        '{kpos(64'sd3963377774), kpos(64'sd2158037573)},
        '{kneg(64'sd1055613458), kneg(64'sd638541728)},
        '{kneg(64'sd894841775),  kneg(64'sd12914855480)}
    };

    localparam coef_t MAT_OUT [3][3] = '{
        '{kpos(64'sd40767416621), kneg(64'sd33077115913), kpos(64'sd2309699292)},
        '{kneg(64'sd12684380046), kpos(64'sd26097574011), kneg(64'sd3413193965)},
        '{kneg(64'sd41960863),    kneg(64'sd7034186147),  kpos(64'sd17076147010)}
    };

endpackage

// ----- src/oklab_to_linear_rgb_top.sv -----
// ----------------------------------------------------------------------------
// oklab_to_linear_rgb_top: OKLab to linear RGB pixel converter
// Fixed-point OKLab -> LMS' -> signed cube -> linear RGB, clamped to [0, 1].
// ----------------------------------------------------------------------------
// Usage:
//   Pixel request channel: pixel_valid / pixel_stall with lightness, axis_a,
//   axis_b and frame_end. A request is taken on a clock edge where
//   pixel_valid is high and pixel_stall is low.
//   Result channel: rgb_valid / rgb_stall with red, green, blue and
//   frame_end_out; taken where rgb_valid is high and rgb_stall is low.
//   The pipeline has 7 stages (five stages for the
//   LMS' cube, two for the output matrix and clamp); one request per cycle while pixel_stall is low.
//   Each stage holds its own valid bit, so bubbles fill up while the
//   receiver stalls; pixel_stall rises only once every stage is occupied.
//   Results are kept in the output register until taken; nothing is
//   dropped or duplicated.
//   Reset (rst_n low, asynchronous) empties the pipeline; the block keeps
//   no other state.
// ----------------------------------------------------------------------------
module oklab_to_linear_rgb_top
    import okl_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pixel_valid,
    output logic                   pixel_stall,
    input  logic [LUM_W-1:0]       lightness,
    input  logic signed [AB_W-1:0] axis_a,
    input  logic signed [AB_W-1:0] axis_b,
    input  logic                   frame_end,
    output logic                   rgb_valid,
    input  logic                   rgb_stall,
    output logic [CH_W-1:0]        red,
    output logic [CH_W-1:0]        green,
    output logic [CH_W-1:0]        blue,
    output logic                   frame_end_out
);

    localparam int CUBE_W = 48 - (2 * FRAC_BITS - GUARD_BITS);

    logic                   front_ready;
    logic                   mid_valid;
    logic                   mid_ready;
    logic [2:0][CUBE_W-1:0] mid_cube;
    logic                   mid_fe;

    okl_lms_cube #(.FRAC_BITS(FRAC_BITS)) u_lms_cube
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (pixel_valid),
        .in_ready      (front_ready),
        .lightness     (lightness),
        .axis_a        (axis_a),
        .axis_b        (axis_b),
        .frame_end     (frame_end),
        .out_valid     (mid_valid),
        .out_ready     (mid_ready),
        .cube          (mid_cube),
        .frame_end_out (mid_fe)
    );

    okl_rgb_mix #(.FRAC_BITS(FRAC_BITS)) u_rgb_mix
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (mid_valid),
        .in_ready      (mid_ready),
        .cube          (mid_cube),
        .frame_end     (mid_fe),
        .out_valid     (rgb_valid),
        .out_ready     (!rgb_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .frame_end_out (frame_end_out)
    );

    assign pixel_stall = !front_ready;

endmodule

// ----- src/okl_lms_cube.sv -----
// ----------------------------------------------------------------------------
// okl_lms_cube: OKLab -> signed cube of LMS'
// Five-stage pipeline: matrix products, sum and round, square, cube, round.
// ----------------------------------------------------------------------------
module okl_lms_cube
    import okl_pkg::*;
#(
    parameter int FRAC_BITS = 14,
    localparam int SH1    = 2 * FRAC_BITS - GUARD_BITS,
    localparam int CUBE_W = 48 - SH1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [LUM_W-1:0]             lightness,
    input  logic signed [AB_W-1:0]       axis_a,
    input  logic signed [AB_W-1:0]       axis_b,
    input  logic                         frame_end,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0][CUBE_W-1:0]       cube,
    output logic                         frame_end_out
);

    localparam int PROD1_W = AB_W + COEF_W;
    localparam int ACC1_W  = PROD1_W + 2;
    localparam int P_W     = 18;
    localparam int PP_W    = 32;
    localparam int PPP_W   = 48;
    localparam logic signed [ACC1_W-1:0] HALF1 = ACC1_W'(1) << (COEF_BITS - 1);
    localparam logic signed [PPP_W-1:0]  HALF3 = PPP_W'(1) << (SH1 - 1);

    logic go1, go2, go3, go4, go5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic [LUM_W-1:0]          lum1_reg;
    logic signed [PROD1_W-1:0] pa1_reg [3];
    logic signed [PROD1_W-1:0] pb1_reg [3];
    logic signed [P_W-1:0]     p2_reg [3];
    logic signed [PP_W-1:0]    pp3_reg [3];
    logic signed [P_W-1:0]     p3_reg [3];
    logic signed [PPP_W-1:0]   ppp4_reg [3];
    logic [2:0][CUBE_W-1:0]    cube5_reg;
    logic fe1_reg, fe2_reg, fe3_reg, fe4_reg, fe5_reg;

    logic signed [ACC1_W-1:0]    lum_term;
    logic signed [ACC1_W-1:0]    acc1 [3];
    logic signed [P_W-1:0]       p_next [3];
    logic signed [2*P_W-1:0]     sq [3];
    logic signed [PP_W+P_W-1:0]  cb_full [3];
    logic signed [PPP_W-1:0]     ppp_rnd [3];

    function automatic logic [LUM_W:0] lightness_pad(input logic [LUM_W-1:0] v);
        return {1'b0, v};
    endfunction

    assign go5      = !v5_reg || out_ready;
    assign go4      = !v4_reg || go5;
    assign go3      = !v3_reg || go4;
    assign go2      = !v2_reg || go3;
    assign go1      = !v1_reg || go2;
    assign in_ready = go1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (go1) v1_reg <= in_valid;
            if (go2) v2_reg <= v1_reg;
            if (go3) v3_reg <= v2_reg;
            if (go4) v4_reg <= v3_reg;
            if (go5) v5_reg <= v4_reg;
        end
    end

    always_comb
    begin
        lum_term = ACC1_W'({lightness_pad(lum1_reg), {COEF_BITS{1'b0}}});
        for (int i = 0; i < 3; i++)
        begin
            acc1[i]    = ACC1_W'(pa1_reg[i]) + ACC1_W'(pb1_reg[i]) + lum_term + HALF1;
            p_next[i]  = acc1[i][COEF_BITS+P_W-1:COEF_BITS];
            sq[i]      = p2_reg[i] * p2_reg[i];
            cb_full[i] = pp3_reg[i] * p3_reg[i];
            ppp_rnd[i] = ppp4_reg[i] + HALF3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go1 && in_valid)
        begin
            lum1_reg <= lightness;
            fe1_reg  <= frame_end;
            for (int i = 0; i < 3; i++)
            begin
                pa1_reg[i] <= axis_a * MAT_IN[i][0];
                pb1_reg[i] <= axis_b * MAT_IN[i][1];
            end
        end
        if (go2 && v1_reg)
        begin
            fe2_reg <= fe1_reg;
            for (int i = 0; i < 3; i++)
                p2_reg[i] <= p_next[i];
        end
        if (go3 && v2_reg)
        begin
            fe3_reg <= fe2_reg;
            for (int i = 0; i < 3; i++)
            begin
                pp3_reg[i] <= sq[i][PP_W-1:0];
                p3_reg[i]  <= p2_reg[i];
            end
        end
        if (go4 && v3_reg)
        begin
            fe4_reg <= fe3_reg;
            for (int i = 0; i < 3; i++)
                ppp4_reg[i] <= cb_full[i][PPP_W-1:0];
        end
        if (go5 && v4_reg)
        begin
            fe5_reg <= fe4_reg;
            for (int i = 0; i < 3; i++)
                cube5_reg[i] <= ppp_rnd[i][SH1+CUBE_W-1:SH1];
        end
    end

    assign out_valid     = v5_reg;
    assign cube          = cube5_reg;
    assign frame_end_out = fe5_reg;

endmodule

// ----- src/okl_rgb_mix.sv -----
// ----------------------------------------------------------------------------
// okl_rgb_mix: LMS cube -> clamped linear RGB
// Two-stage pipeline: matrix products, then sum, round and clamp to [0, 1].
// ----------------------------------------------------------------------------
module okl_rgb_mix
    import okl_pkg::*;
#(
    parameter int FRAC_BITS = 14,
    localparam int SH1    = 2 * FRAC_BITS - GUARD_BITS,
    localparam int CUBE_W = 48 - SH1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0][CUBE_W-1:0] cube,
    input  logic                   frame_end,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CH_W-1:0]        red,
    output logic [CH_W-1:0]        green,
    output logic [CH_W-1:0]        blue,
    output logic                   frame_end_out
);

    localparam int PROD2_W = CUBE_W + COEF_W;
    localparam int ACC2_W  = PROD2_W + 2;
    localparam int SH2     = COEF_BITS + GUARD_BITS;
    localparam logic signed [ACC2_W-1:0] HALF2 = ACC2_W'(1) << (SH2 - 1);
    localparam logic signed [ACC2_W-1:0] ONE   = ACC2_W'(1) << FRAC_BITS;

    logic go6, go7;
    logic v6_reg, v7_reg;
    logic fe6_reg, fe7_reg;
    logic signed [PROD2_W-1:0] prod6_reg [3][3];
    logic [CH_W-1:0]           ch7_reg [3];

    logic signed [ACC2_W-1:0] acc2 [3];
    logic signed [ACC2_W-1:0] lvl [3];
    logic signed [ACC2_W-1:0] sat [3];
    logic [CH_W-1:0]          ch_next [3];

    assign go7      = !v7_reg || out_ready;
    assign go6      = !v6_reg || go7;
    assign in_ready = go6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (go6) v6_reg <= in_valid;
            if (go7) v7_reg <= v6_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc2[i] = ACC2_W'(prod6_reg[i][0]) + ACC2_W'(prod6_reg[i][1])
                    + ACC2_W'(prod6_reg[i][2]) + HALF2;
            lvl[i]  = acc2[i] >>> SH2;
            if (lvl[i] < 0)
                sat[i] = '0;
            else if (lvl[i] > ONE)
                sat[i] = ONE;
            else
                sat[i] = lvl[i];
            ch_next[i] = sat[i][CH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (go6 && in_valid)
        begin
            fe6_reg <= frame_end;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    prod6_reg[i][j] <= $signed(cube[j]) * MAT_OUT[i][j];
        end
        if (go7 && v6_reg)
        begin
            fe7_reg <= fe6_reg;
            for (int i = 0; i < 3; i++)
                ch7_reg[i] <= ch_next[i];
        end
    end

    assign out_valid     = v7_reg;
    assign red           = ch7_reg[0];
    assign green         = ch7_reg[1];
    assign blue          = ch7_reg[2];
    assign frame_end_out = fe7_reg;

endmodule
